// File: rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int NUM_SLOTS   = 4;
  localparam int CNT_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;

  localparam logic [7:0] BLANK_PATTERN = 8'h10;
  localparam logic [7:0] SELECT_BASE   = 8'h10;
  localparam logic [3:0] KEY_MAX       = 4'd11;
  localparam logic [3:0] LIMIT_MIN     = 4'd1;
  localparam logic [3:0] LIMIT_MAX     = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOURTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_TICK   = 3'd0;
  localparam logic [2:0] ST_DIGIT  = 3'd1;
  localparam logic [2:0] ST_OK     = 3'd2;
  localparam logic [2:0] ST_WRONG  = 3'd3;
  localparam logic [2:0] ST_LOCKED = 3'd4;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_KEY,
    KIND_NOP
  } kind_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [3:0] key;
    logic [7:0] pattern;
  } op_t;

  typedef struct packed {
    logic       siren_on;
    logic [7:0] select_byte;
    logic [7:0] segment_byte;
    logic [1:0] digits_entered;
    logic [3:0] tries_remaining;
    logic [2:0] status;
  } result_t;

  function automatic logic [7:0] key_pattern(input logic [3:0] key);
    logic [7:0] pat;
    unique case (key)
      4'd0:    pat = 8'hFC;
      4'd1:    pat = 8'h60;
      4'd2:    pat = 8'hDA;
      4'd3:    pat = 8'hF2;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'hB6;
      4'd6:    pat = 8'hBE;
      4'd7:    pat = 8'hE0;
      4'd8:    pat = 8'hFE;
      4'd9:    pat = 8'hF6;
      4'd10:   pat = 8'hEE;
      4'd11:   pat = 8'h3E;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/core/kcl_front.sv
`timescale 1ns / 1ps

module kcl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_action,
  input  logic [3:0]     in_key,
  output logic           op_valid,
  input  logic           op_ready,
  output kcl_pkg::op_t   op
);
  import kcl_pkg::*;

  logic vld_r, vld_nxt;
  op_t  op_r, op_nxt;

  assign in_ready = !vld_r || op_ready;
  assign op_valid = vld_r;
  assign op       = op_r;

  // classify: tick, valid key, or a key code that does nothing
  always_comb begin
    op_nxt.key     = in_key;
    op_nxt.pattern = key_pattern(in_key);
    if (in_action) begin
      op_nxt.kind = KIND_TICK;
    end else if (in_key <= KEY_MAX) begin
      op_nxt.kind = KIND_KEY;
    end else begin
      op_nxt.kind = KIND_NOP;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (op_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op_nxt;
    end
  end

endmodule

// File: rtl/core/kcl_queue.sv
`timescale 1ns / 1ps

module kcl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  kcl_pkg::op_t   wr_op,
  output logic           rd_valid,
  input  logic           rd_ready,
  output kcl_pkg::op_t   rd_op
);
  import kcl_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_op    = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

// File: rtl/core/kcl_back.sv
`timescale 1ns / 1ps

module kcl_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             op_valid,
  output logic                             op_ready,
  input  kcl_pkg::op_t                     op,
  output logic                             res_valid,
  input  logic                             res_ready,
  output kcl_pkg::result_t                 res
);
  import kcl_pkg::*;

  logic [3:0]       code_r [NUM_SLOTS];
  logic [3:0]       limit_r;

  logic [7:0]       disp_r [NUM_SLOTS];
  logic [7:0]       disp_nxt [NUM_SLOTS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       tries_r, tries_nxt;
  logic [1:0]       scan_r, scan_nxt;
  logic [7:0]       blink_r, blink_nxt;
  logic             siren_r, siren_nxt;
  logic             mm_r, mm_nxt;

  logic             res_vld_r, res_vld_nxt;
  result_t          res_r, res_nxt;

  logic             fire;
  logic [1:0]       slot;
  logic [3:0]       limit_sat;
  logic [7:0]       onehot;

  assign op_ready  = !res_vld_r || res_ready;
  assign fire      = op_valid && op_ready;
  assign res_valid = res_vld_r;
  assign res       = res_r;
  assign slot      = cnt_r[1:0];
  assign onehot    = SELECT_BASE << scan_r;

  always_comb begin
    priority if (limit_r < LIMIT_MIN) begin
      limit_sat = LIMIT_MIN;
    end else if (limit_r > LIMIT_MAX) begin
      limit_sat = LIMIT_MAX;
    end else begin
      limit_sat = limit_r;
    end
  end

  always_comb begin
    disp_nxt  = disp_r;
    cnt_nxt   = cnt_r;
    tries_nxt = tries_r;
    scan_nxt  = scan_r;
    blink_nxt = blink_r;
    siren_nxt = siren_r;
    mm_nxt    = mm_r;
    res_nxt   = '0;
    res_nxt.status = ST_TICK;

    unique case (op.kind)
      KIND_TICK: begin
        if (tries_r == 4'd0) begin
          blink_nxt = blink_r + 8'd1;
          if (!blink_nxt[4]) begin
            siren_nxt = !siren_r;
          end
        end
        res_nxt.segment_byte = disp_r[2'd3 - scan_r];
        res_nxt.select_byte  = ~onehot;
        scan_nxt             = scan_r + 2'd1;
      end
      KIND_KEY: begin
        disp_nxt[slot] = op.pattern;
        mm_nxt         = mm_r || (code_r[slot] != op.key);
        cnt_nxt        = cnt_r + CNT_W'(1);
        res_nxt.status = ST_DIGIT;
        if ({1'b0, cnt_r} + 4'd1 >= 4'(CODE_LENGTH)) begin
          if (!mm_nxt) begin
            tries_nxt      = limit_sat;
            blink_nxt      = 8'd0;
            res_nxt.status = ST_OK;
          end else begin
            if (tries_r != 4'd0) begin
              tries_nxt = tries_r - 4'd1;
            end
            res_nxt.status = (tries_nxt == 4'd0) ? ST_LOCKED : ST_WRONG;
          end
          cnt_nxt = '0;
          mm_nxt  = 1'b0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            disp_nxt[i] = BLANK_PATTERN;
          end
        end
      end
      default: begin
      end
    endcase

    // siren stays off unless locked out
    if (tries_nxt != 4'd0) begin
      siren_nxt = 1'b0;
    end

    res_nxt.tries_remaining = tries_nxt;
    res_nxt.digits_entered  = cnt_nxt[1:0];
    res_nxt.siren_on        = siren_nxt;
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (fire) begin
      res_vld_nxt = 1'b1;
    end else if (res_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r[0] <= 4'd5;
      code_r[1] <= 4'd1;
      code_r[2] <= 4'd9;
      code_r[3] <= 4'd4;
      limit_r   <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CODE_FIRST:  code_r[0] <= cfg_wdata;
        CFG_CODE_SECOND: code_r[1] <= cfg_wdata;
        CFG_CODE_THIRD:  code_r[2] <= cfg_wdata;
        CFG_CODE_FOURTH: code_r[3] <= cfg_wdata;
        CFG_TRY_LIMIT:   limit_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        disp_r[i] <= BLANK_PATTERN;
      end
      cnt_r     <= '0;
      tries_r   <= 4'd4;
      scan_r    <= 2'd0;
      blink_r   <= 8'd0;
      siren_r   <= 1'b0;
      mm_r      <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (fire) begin
        disp_r  <= disp_nxt;
        cnt_r   <= cnt_nxt;
        tries_r <= tries_nxt;
        scan_r  <= scan_nxt;
        blink_r <= blink_nxt;
        siren_r <= siren_nxt;
        mm_r    <= mm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/core/keypad_code_lock_display_unit.sv
`timescale 1ns / 1ps

// Keypad code lock with a four-digit seven-segment display. Each input word
// is either a key press (in_tuser = 0, key code 0-9, 10 star, 11 hash in
// in_tdata) or a display scan tick (in_tuser = 1), and each produces exactly
// one result word. Keys fill the display slots in order; the fourth key is
// judged against the code registers, which unlocks and restores the tries or
// takes a try off and locks out at zero, and then blanks the display. A tick
// returns the segment byte and the inverted digit select of the next of four
// digits and, during lockout, drives the siren in 16-tick bursts. Key codes
// 12-15 are dropped with a status of zero. The block sustains one word per
// clock while out_tready is held high; a result passes through the front
// classify register, the two-entry queue and the output register of the
// execute stage. Write configuration only while idle.

module keypad_code_lock_display_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [3:0] key, [7:4] zero
  input  logic                             in_tuser,   // [0] action
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] status, [6:3] tries_remaining, [8:7] digits_entered,
  // [16:9] segment_byte, [24:17] select_byte, [25] siren_on, [31:26] zero
  output logic [31:0]                      out_tdata
);
  import kcl_pkg::*;

  op_t     f_op, q_op;
  logic    f_valid, f_ready;
  logic    q_valid, q_ready;
  result_t res;

  // front: register and classify each incoming word
  kcl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_key   (in_tdata[3:0]),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  // short queue lets front and back stall independently
  kcl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_op   (f_op),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_op   (q_op)
  );

  // back: lock state, display slots, siren, and the output register
  kcl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op       (q_op),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  // pack the result word, status in the lowest bits
  assign out_tdata = {6'd0, res};

endmodule
